// ===== hw/rtl/substring_first_match_search_top_assert.svh =====
// Assertion helpers shared by the RTL of the substring search block.
`ifndef SUBSTRING_FIRST_MATCH_SEARCH_TOP_ASSERT_SVH
`define SUBSTRING_FIRST_MATCH_SEARCH_TOP_ASSERT_SVH

// Same-cycle implication, disabled while reset is asserted.
`define SFMS_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("same-cycle check failed");

// Next-cycle implication, disabled while reset is asserted.
`define SFMS_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("next-cycle check failed");

`endif

// ===== hw/rtl/sfms_pkg.sv =====
package sfms_pkg;

    localparam int BYTE_W            = 8;
    localparam int NEEDLE_MAX_DEF    = 64;
    localparam int POSITION_BITS_DEF = 32;
    localparam int SLOT_W            = 6;
    localparam int LEN_REG_W         = 7;
    localparam int OUT_POS_W         = 32;
    localparam int CFG_IDX_W         = 4;
    localparam int CFG_DATA_W        = 8;

    localparam logic [CFG_IDX_W-1:0] REG_PATTERN_LENGTH = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] REG_FOLD_CASE      = CFG_IDX_W'(1);

    localparam logic MODE_PATTERN = 1'b0;
    localparam logic MODE_TEXT    = 1'b1;

    typedef struct packed {
        logic                  valid;
        logic [SLOT_W-1:0]     slot;
        logic [BYTE_W-1:0]     value;
    } t_pat_wr;

    typedef struct packed {
        logic                  valid;
        logic [CFG_IDX_W-1:0]  index;
        logic [CFG_DATA_W-1:0] data;
    } t_cfg_wr;

    // Maps ASCII upper-case letters to lower case when folding is enabled.
    function automatic logic [BYTE_W-1:0] f_fold(input logic [BYTE_W-1:0] c,
                                                 input logic en);
        logic [BYTE_W-1:0] r;
        r = c;
        if (en && (c >= 8'h41) && (c <= 8'h5A)) begin
            r = c + 8'h20;
        end
        return r;
    endfunction

endpackage

// ===== hw/rtl/sfms_if.sv =====
interface sfms_in_if;
    logic       valid;
    logic       ready;
    logic       mode;
    logic [7:0] byte_value;
    logic [5:0] pattern_index;
    logic       last_byte;

    modport source (output valid, output mode, output byte_value,
                    output pattern_index, output last_byte, input ready);
    modport sink   (input valid, input mode, input byte_value,
                    input pattern_index, input last_byte, output ready);
endinterface

interface sfms_out_if;
    logic        valid;
    logic        ready;
    logic        found;
    logic [31:0] match_position;

    modport source (output valid, output found, output match_position, input ready);
    modport sink   (input valid, input found, input match_position, output ready);
endinterface

interface sfms_cfg_if;
    logic       valid;
    logic       ready;
    logic [3:0] index;
    logic [7:0] data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

// ===== hw/rtl/sfms_cell.sv =====
module sfms_cell (
    input  logic                         i_clk,
    input  logic                         i_shift,
    input  logic [sfms_pkg::BYTE_W-1:0]  i_byte,
    input  logic                         i_fold,
    input  logic [sfms_pkg::BYTE_W-1:0]  i_pat_byte,
    input  logic                         i_care,
    output logic [sfms_pkg::BYTE_W-1:0]  o_byte,
    output logic                         o_eq
);
    import sfms_pkg::*;

    logic [BYTE_W-1:0] r_byte;

    // One window byte; it moves to the next cell on every text request.
    always_ff @(posedge i_clk) begin
        if (i_shift) begin
            r_byte <= i_byte;
        end
    end

    assign o_byte = r_byte;
    // The pattern byte arrives already folded.
    assign o_eq   = !i_care || (f_fold(r_byte, i_fold) == i_pat_byte);

endmodule

// ===== hw/rtl/sfms_pattern.sv =====
module sfms_pattern #(
    parameter int NEEDLE_MAX = sfms_pkg::NEEDLE_MAX_DEF,
    parameter int LEN_W      = $clog2(NEEDLE_MAX + 1)
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  sfms_pkg::t_pat_wr                  i_pat_wr,
    input  sfms_pkg::t_cfg_wr                  i_cfg_wr,
    output logic [NEEDLE_MAX*sfms_pkg::BYTE_W-1:0] o_pat_bytes,
    output logic [NEEDLE_MAX-1:0]              o_care,
    output logic [LEN_W-1:0]                   o_len,
    output logic                               o_fold
);
    import sfms_pkg::*;

    localparam int IDX_W = (NEEDLE_MAX > 1) ? $clog2(NEEDLE_MAX) : 1;
    localparam int LCW   = (LEN_W > LEN_REG_W) ? LEN_W : LEN_REG_W;

    logic [BYTE_W-1:0]            r_pat [NEEDLE_MAX];
    logic [LEN_REG_W-1:0]         r_len;
    logic                         r_fold;
    logic [LEN_REG_W-1:0]         n_len;
    logic                         n_fold;
    logic                         wr_hit;
    logic [LCW-1:0]               len_nz;
    logic [LEN_W-1:0]             len_eff;
    logic [LEN_W-1:0]             shift_amt;
    logic [NEEDLE_MAX*BYTE_W-1:0] rev;
    logic [NEEDLE_MAX-1:0]        care;
    logic [NEEDLE_MAX*BYTE_W-1:0] r_pat_bytes;
    logic [NEEDLE_MAX-1:0]        r_care;
    logic [LEN_W-1:0]             r_len_eff;
    logic                         r_fold_q;

    assign wr_hit = i_pat_wr.valid && (32'(i_pat_wr.slot) < NEEDLE_MAX);

    always_comb begin
        n_len  = r_len;
        n_fold = r_fold;
        if (i_cfg_wr.valid && (i_cfg_wr.index == REG_PATTERN_LENGTH)) begin
            n_len = i_cfg_wr.data[LEN_REG_W-1:0];
        end
        if (i_cfg_wr.valid && (i_cfg_wr.index == REG_FOLD_CASE)) begin
            n_fold = i_cfg_wr.data[0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_len  <= LEN_REG_W'(1);
            r_fold <= 1'b0;
        end else begin
            r_len  <= n_len;
            r_fold <= n_fold;
        end
    end

    always_ff @(posedge i_clk) begin
        if (wr_hit) begin
            r_pat[IDX_W'(i_pat_wr.slot)] <= i_pat_wr.value;
        end
    end

    // A length of zero acts as one; lengths above the store depth are clipped.
    always_comb begin
        len_nz = (n_len == '0) ? LCW'(1) : LCW'(n_len);
        if (len_nz > LCW'(NEEDLE_MAX)) begin
            len_nz = LCW'(NEEDLE_MAX);
        end
        len_eff   = LEN_W'(len_nz);
        shift_amt = LEN_W'(NEEDLE_MAX) - len_eff;
    end

    // Reverse the pattern (with this cycle's write forwarded), then shift so
    // that window cell j lines up with pattern byte len-1-j.
    always_comb begin
        for (int j = 0; j < NEEDLE_MAX; j++) begin
            if (wr_hit && (32'(i_pat_wr.slot) == NEEDLE_MAX - 1 - j)) begin
                rev[j*BYTE_W +: BYTE_W] = f_fold(i_pat_wr.value, n_fold);
            end else begin
                rev[j*BYTE_W +: BYTE_W] = f_fold(r_pat[NEEDLE_MAX - 1 - j], n_fold);
            end
            care[j] = (32'(j) < 32'(len_eff));
        end
    end

    always_ff @(posedge i_clk) begin
        r_pat_bytes <= rev >> {shift_amt, 3'b000};
        r_care      <= care;
        r_len_eff   <= len_eff;
        r_fold_q    <= n_fold;
    end

    assign o_pat_bytes = r_pat_bytes;
    assign o_care      = r_care;
    assign o_len       = r_len_eff;
    assign o_fold      = r_fold_q;

endmodule

// ===== hw/rtl/substring_first_match_search_top.sv =====
// The accepting edge shifts the text byte into the window and the compare stage; for a
// first match or a last byte that stage loads the result register, which presents it.
// Throughput: one request per cycle, pattern writes and text bytes alike; the input
// stalls only while a result in the compare stage waits behind an unaccepted one.
// A pattern write or register change is seen by the very next text byte. Reset
// (synchronous, active low) clears the search state; the pattern store stays undefined.
`include "substring_first_match_search_top_assert.svh"

module substring_first_match_search_top #(
    parameter int NEEDLE_MAX    = sfms_pkg::NEEDLE_MAX_DEF,
    parameter int POSITION_BITS = sfms_pkg::POSITION_BITS_DEF
) (
    input logic        i_clk,
    input logic        i_rst_n,
    sfms_in_if.sink    i_in,
    sfms_out_if.source o_res,
    sfms_cfg_if.sink   i_cfg
);
    import sfms_pkg::*;

    localparam int LEN_W = $clog2(NEEDLE_MAX + 1);
    localparam int CW    = (POSITION_BITS > LEN_W) ? POSITION_BITS : LEN_W;

    t_pat_wr                      pat_wr;
    t_cfg_wr                      cfg_wr;
    logic [NEEDLE_MAX*BYTE_W-1:0] pat_bytes;
    logic [NEEDLE_MAX-1:0]        care;
    logic [LEN_W-1:0]             len;
    logic                         fold;
    logic [NEEDLE_MAX*BYTE_W-1:0] win;
    logic [NEEDLE_MAX-1:0]        eq;

    logic                         text_acc;
    logic                         s1_adv;
    logic                         hit;
    logic                         s1_found;
    logic                         s1_res;
    logic                         out_load;
    logic [POSITION_BITS-1:0]     cnt_inc;

    logic                         r_s1_v;
    logic                         r_s1_last;
    logic [POSITION_BITS-1:0]     r_s1_pos;
    logic [POSITION_BITS-1:0]     r_cnt;
    logic                         r_match;
    logic                         r_out_v;
    logic                         r_out_found;
    logic [OUT_POS_W-1:0]         r_out_pos;
    logic                         n_s1_v;
    logic [POSITION_BITS-1:0]     n_cnt;
    logic                         n_match;
    logic                         n_out_v;

    assign pat_wr.valid = i_in.valid && i_in.ready && (i_in.mode == MODE_PATTERN);
    assign pat_wr.slot  = i_in.pattern_index;
    assign pat_wr.value = i_in.byte_value;

    assign i_cfg.ready  = 1'b1;
    assign cfg_wr.valid = i_cfg.valid;
    assign cfg_wr.index = i_cfg.index;
    assign cfg_wr.data  = i_cfg.data;

    sfms_pattern #(
        .NEEDLE_MAX (NEEDLE_MAX),
        .LEN_W      (LEN_W)
    ) u_pattern (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_pat_wr    (pat_wr),
        .i_cfg_wr    (cfg_wr),
        .o_pat_bytes (pat_bytes),
        .o_care      (care),
        .o_len       (len),
        .o_fold      (fold)
    );

    assign text_acc = i_in.valid && i_in.ready && (i_in.mode == MODE_TEXT);

    // Cell 0 holds the newest text byte; each cell passes its byte on.
    for (genvar j = 0; j < NEEDLE_MAX; j++) begin : g_cell
        logic [BYTE_W-1:0] cell_in;
        if (j == 0) begin : g_head
            assign cell_in = i_in.byte_value;
        end else begin : g_link
            assign cell_in = win[(j-1)*BYTE_W +: BYTE_W];
        end
        sfms_cell u_cell (
            .i_clk      (i_clk),
            .i_shift    (text_acc),
            .i_byte     (cell_in),
            .i_fold     (fold),
            .i_pat_byte (pat_bytes[j*BYTE_W +: BYTE_W]),
            .i_care     (care[j]),
            .o_byte     (win[j*BYTE_W +: BYTE_W]),
            .o_eq       (eq[j])
        );
    end

    // Only a window filled entirely by this search's bytes may match.
    assign hit      = (CW'(r_s1_pos) >= CW'(len)) && (&eq);
    assign s1_found = !r_match && hit;
    assign s1_res   = r_s1_v && !r_match && (hit || r_s1_last);
    assign s1_adv   = !r_s1_v || !s1_res || !r_out_v || o_res.ready;
    assign out_load = s1_res && s1_adv;

    assign i_in.ready = s1_adv;

    assign cnt_inc = (&r_cnt) ? r_cnt : r_cnt + POSITION_BITS'(1);

    always_comb begin
        n_cnt = r_cnt;
        if (text_acc) begin
            n_cnt = i_in.last_byte ? '0 : cnt_inc;
        end
        n_s1_v  = s1_adv ? text_acc : r_s1_v;
        n_match = r_match;
        if (r_s1_v && s1_adv) begin
            n_match = r_s1_last ? 1'b0 : (r_match || hit);
        end
        n_out_v = out_load || (r_out_v && !o_res.ready);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt   <= '0;
            r_s1_v  <= 1'b0;
            r_match <= 1'b0;
            r_out_v <= 1'b0;
        end else begin
            r_cnt   <= n_cnt;
            r_s1_v  <= n_s1_v;
            r_match <= n_match;
            r_out_v <= n_out_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (text_acc && s1_adv) begin
            r_s1_last <= i_in.last_byte;
            r_s1_pos  <= cnt_inc;
        end
        if (out_load) begin
            r_out_found <= s1_found;
            r_out_pos   <= s1_found
                ? OUT_POS_W'(POSITION_BITS'(CW'(r_s1_pos) - CW'(len)))
                : '0;
        end
    end

    assign o_res.valid          = r_out_v;
    assign o_res.found          = r_out_found;
    assign o_res.match_position = r_out_pos;

    `SFMS_ASSERT_NOW(a_no_second_match, i_clk, i_rst_n, r_s1_v && r_match, !s1_res)
    `SFMS_ASSERT_NEXT(a_last_clears_match, i_clk, i_rst_n,
        r_s1_v && s1_adv && r_s1_last, !r_match)
    `SFMS_ASSERT_NEXT(a_last_clears_count, i_clk, i_rst_n,
        text_acc && i_in.last_byte, r_cnt == '0)
    `SFMS_ASSERT_NOW(a_full_output_stalls, i_clk, i_rst_n,
        s1_res && r_out_v && !o_res.ready, !i_in.ready)

endmodule
